/* design/fkvc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkvc_pkg
// Shared constants and types of the FIFO-replacement key/value cache.
// ----------------------------------------------------------------------------
package fkvc_pkg;

  localparam int Capacity = 16;
  localparam int SlotW    = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CountW   = $clog2(Capacity + 1);
  localparam int DataW    = 32;

  localparam logic OpGet = 1'b0;
  localparam logic OpSet = 1'b1;

  typedef logic [SlotW-1:0]  slot_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [DataW-1:0]  word_t;

  // live window of the slot ring
  typedef struct packed {
    slot_t  oldest;
    count_t fill;
  } fkvc_ptr_t;

  // outcome of the associative key search
  typedef struct packed {
    logic  hit;
    slot_t slot;
  } fkvc_match_t;

endpackage

/* design/fkvc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkvc request / response channels
// Valid/ready channels carrying cache requests and their results.
// ----------------------------------------------------------------------------
interface fkvc_req_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface fkvc_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface

/* design/fifo_replacement_kv_cache_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_replacement_kv_cache_unit
// Fully associative key/value cache with first-in-first-out replacement.
// A get returns the stored value with hit set, or -1 with hit clear. A set
// updates a present key in place, otherwise appends, evicting the oldest
// entry when all Capacity slots are in use; a set always returns -1 and
// hit tells whether the key was present. Keys sit in registers and are
// compared in parallel in the accept cycle; values live in a synchronous
// RAM. In the accept cycle the search, the key/value writes and the value
// read are done; the registered RAM read then waits as a pending beat until
// the output register is free and the beat moves into it.
// A new request is taken once the previous one has moved to the output
// register, even while that result is still waiting to be taken.
// ----------------------------------------------------------------------------
module fifo_replacement_kv_cache_unit (
  input logic         clk_i,
  input logic         rst_ni,
  fkvc_req_if.sink    req_i,
  fkvc_rsp_if.source  rsp_o
);
  import fkvc_pkg::*;

  localparam word_t MissValue = '1;

  slot_t       oldest_q, oldest_d;
  count_t      fill_q, fill_d;
  logic        pend_q, pend_d;
  logic        pend_hit_q;
  logic        pend_get_q;
  logic        out_valid_q, out_valid_d;
  logic        out_hit_q;
  word_t       out_value_q;

  fkvc_ptr_t   ptr;
  fkvc_match_t match;
  logic        accept;
  logic        is_set;
  logic        full;
  logic [CountW:0] append_sum;
  slot_t       append_slot;
  slot_t       new_slot;
  slot_t       oldest_next;
  logic        insert;
  logic        mem_we;
  slot_t       mem_waddr;
  logic        mem_re;
  word_t       mem_rdata;
  logic        drain;

  assign ptr.oldest = oldest_q;
  assign ptr.fill   = fill_q;

  assign req_i.ready = !pend_q;
  assign accept      = req_i.valid && req_i.ready;
  assign is_set      = (req_i.op == OpSet);
  assign full        = (fill_q == CountW'(Capacity));

  // ring position after the youngest entry
  always_comb begin
    append_sum = (CountW+1)'(oldest_q) + (CountW+1)'(fill_q);
    if (append_sum >= (CountW+1)'(Capacity)) begin
      append_sum = append_sum - (CountW+1)'(Capacity);
    end
    append_slot = SlotW'(append_sum);
    oldest_next = (oldest_q == SlotW'(Capacity - 1)) ? '0 : oldest_q + SlotW'(1);
  end

  assign new_slot  = full ? oldest_q : append_slot;
  assign insert    = accept && is_set && !match.hit;
  assign mem_we    = accept && is_set;
  assign mem_waddr = match.hit ? match.slot : new_slot;
  assign mem_re    = accept && !is_set && match.hit;

  fkvc_tags u_tags (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ptr_i   (ptr),
    .key_i   (word_t'(req_i.key)),
    .we_i    (insert),
    .wslot_i (new_slot),
    .wkey_i  (word_t'(req_i.key)),
    .match_o (match)
  );

  fkvc_ram #(
    .Width (DataW),
    .Depth (Capacity)
  ) u_values (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (word_t'(req_i.value)),
    .re_i    (mem_re),
    .raddr_i (match.slot),
    .rdata_o (mem_rdata)
  );

  // pending beat moves on once the output register is free
  assign drain = pend_q && (!out_valid_q || rsp_o.ready);

  always_comb begin
    fill_d      = fill_q;
    oldest_d    = oldest_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (insert && !full) begin
      fill_d = fill_q + CountW'(1);
    end
    if (insert && full) begin
      oldest_d = oldest_next;
    end
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (drain) begin
      pend_d      = 1'b0;
      out_valid_d = 1'b1;
    end
    if (accept) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      oldest_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      oldest_q    <= oldest_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_hit_q <= match.hit;
      pend_get_q <= !is_set;
    end
    if (drain) begin
      out_hit_q   <= pend_hit_q;
      out_value_q <= (pend_get_q && pend_hit_q) ? mem_rdata : MissValue;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.hit        = out_hit_q;
  assign rsp_o.read_value = out_value_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CountW'(Capacity))
    else $error("fill count above capacity");

  a_update_keeps_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_set && match.hit) |=> ($stable(fill_q) && $stable(oldest_q)))
    else $error("update of a present key moved the ring");

  a_evict_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oldest_q != $past(oldest_q)) |-> ($past(fill_q) == CountW'(Capacity)))
    else $error("oldest slot advanced while not full");

  a_accept_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pend_q)
    else $error("accepted request not pending");

endmodule

/* design/fkvc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkvc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fkvc_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/fkvc_tags.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkvc_tags
// Key registers with a parallel compare against the live window of the ring.
// ----------------------------------------------------------------------------
module fkvc_tags (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fkvc_pkg::fkvc_ptr_t  ptr_i,
  input  fkvc_pkg::word_t      key_i,
  input  logic                 we_i,
  input  fkvc_pkg::slot_t      wslot_i,
  input  fkvc_pkg::word_t      wkey_i,
  output fkvc_pkg::fkvc_match_t match_o
);
  import fkvc_pkg::*;

  word_t               keys_q [Capacity];
  logic [Capacity-1:0] live;
  logic [Capacity-1:0] match_vec;
  slot_t               hit_slot;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      keys_q[wslot_i] <= wkey_i;
    end
  end

  // slot s is live when its distance from the oldest slot is below the fill
  always_comb begin
    for (int s = 0; s < Capacity; s++) begin
      logic [CountW:0] ring_ofs;
      if (SlotW'(s) >= ptr_i.oldest) begin
        ring_ofs = (CountW+1)'(s) - (CountW+1)'(ptr_i.oldest);
      end else begin
        ring_ofs = (CountW+1)'(s + Capacity) - (CountW+1)'(ptr_i.oldest);
      end
      live[s]      = ring_ofs < (CountW+1)'(ptr_i.fill);
      match_vec[s] = live[s] && (keys_q[s] == key_i);
    end
  end

  // live keys are unique, so the match vector is one-hot or empty
  always_comb begin
    hit_slot = '0;
    for (int s = 0; s < Capacity; s++) begin
      if (match_vec[s]) begin
        hit_slot = hit_slot | SlotW'(s);
      end
    end
  end

  assign match_o.hit  = |match_vec;
  assign match_o.slot = hit_slot;

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec))
    else $error("key matches more than one live slot");

endmodule
